/* sv/dqrs_pkg.sv */
package dqrs_pkg;

    // Fixed-point constants of the term datapath.
    localparam logic [31:0] ONE_ANGSTROM = 32'd65536;
    localparam logic [31:0] LOG2E_Q30    = 32'd1549082005;
    localparam logic [31:0] LN2_Q32      = 32'd2977044472;
    localparam logic [47:0] OUT_MAX      = 48'hFFFF_FFFF_FFFF;
    localparam logic [49:0] T_FAR        = 50'd3276800;
    localparam logic [49:0] T_NEAR       = 50'd2621440;
    localparam logic [32:0] EXP_ONE      = 33'h1_0000_0000;
    localparam logic [3:0]  EXP_LAST_K   = 4'd13;

    // Configuration register indexes.
    localparam logic CFG_PROBE_RADIUS = 1'b0;
    localparam logic CFG_ATOM_COUNT   = 1'b1;

    // One table entry.
    typedef struct packed {
        logic [31:0] decay;
        logic [31:0] rate;
        logic [31:0] z;
        logic [31:0] y;
        logic [31:0] x;
    } t_atom;

    // A classified word on its way from the front to the back.
    typedef struct packed {
        logic        is_query;
        logic [7:0]  idx;
        t_atom       atom;
    } t_item;

    // Handshake and status from the back to the front.
    typedef struct packed {
        logic pop;
        logic clearing;
    } t_back_ctl;

    // ceil(2^36 / k): floor(x / k) equals (x * f_recip(k)) >> 36 for any x below 2^32.
    function automatic logic [36:0] f_recip(input logic [3:0] k);
        logic [36:0] m;
        case (k)
            4'd1:    m = 37'd68719476736;
            4'd2:    m = 37'd34359738368;
            4'd3:    m = 37'd22906492246;
            4'd4:    m = 37'd17179869184;
            4'd5:    m = 37'd13743895348;
            4'd6:    m = 37'd11453246123;
            4'd7:    m = 37'd9817068106;
            4'd8:    m = 37'd8589934592;
            4'd9:    m = 37'd7635497416;
            4'd10:   m = 37'd6871947674;
            4'd11:   m = 37'd6247225158;
            4'd12:   m = 37'd5726623062;
            4'd13:   m = 37'd5286113596;
            default: m = 37'd0;
        endcase
        return m;
    endfunction

endpackage

/* sv/dqrs_front.sv */
module dqrs_front import dqrs_pkg::*; #(
    parameter int MAX_ATOMS = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [167:0] s_axis_tdata,
    input  logic         s_axis_tuser,
    output t_item        o_item,
    output logic         o_item_vld,
    input  t_back_ctl    i_ctl
);

    t_item       r_q [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    t_item       w_item;
    logic [16:0] w_idx_ext;
    logic        w_acc;
    logic        w_push;
    logic        w_pop;

    // Classify the word; a zero decay length stands for one angstrom.
    always_comb begin
        w_item.is_query   = s_axis_tuser;
        w_item.idx        = s_axis_tdata[7:0];
        w_item.atom.x     = s_axis_tdata[39:8];
        w_item.atom.y     = s_axis_tdata[71:40];
        w_item.atom.z     = s_axis_tdata[103:72];
        w_item.atom.rate  = s_axis_tdata[135:104];
        w_item.atom.decay = (s_axis_tdata[167:136] == '0) ? ONE_ANGSTROM
                                                          : s_axis_tdata[167:136];
    end

    assign w_idx_ext     = 17'(s_axis_tdata[7:0]);
    assign s_axis_tready = (r_cnt != 2'd2) && !i_ctl.clearing;
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    // Loads aimed past the table are dropped here.
    assign w_push        = w_acc && (s_axis_tuser || (w_idx_ext < 17'(MAX_ATOMS)));
    assign w_pop         = i_ctl.pop && o_item_vld;

    assign o_item_vld = (r_cnt != 2'd0);
    assign o_item     = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            if (w_push && !w_pop)      r_cnt <= r_cnt + 2'd1;
            else if (!w_push && w_pop) r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_item;
    end

endmodule

/* sv/dqrs_back.sv */
module dqrs_back import dqrs_pkg::*; #(
    parameter int MAX_ATOMS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_item       i_item,
    input  logic        i_item_vld,
    output t_back_ctl   o_ctl,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_wdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tuser
);

    localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int CW = AW + 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_ATOMS - 1);
    localparam logic [16:0]   MAX_EXT   = 17'(MAX_ATOMS);

    typedef enum logic [16:0] {
        S_CLEAR = 17'b00000000000000001,
        S_IDLE  = 17'b00000000000000010,
        S_READ  = 17'b00000000000000100,
        S_DIFF  = 17'b00000000000001000,
        S_SQ    = 17'b00000000000010000,
        S_SQRT  = 17'b00000000000100000,
        S_ARG   = 17'b00000000001000000,
        S_DIV   = 17'b00000000010000000,
        S_CHK   = 17'b00000000100000000,
        S_LOG   = 17'b00000001000000000,
        S_LN    = 17'b00000010000000000,
        S_EXP   = 17'b00000100000000000,
        S_ESUM  = 17'b00001000000000000,
        S_PROD  = 17'b00010000000000000,
        S_SHIFT = 17'b00100000000000000,
        S_ACC   = 17'b01000000000000000,
        S_DONE  = 17'b10000000000000000
    } t_state;

    t_state r_state, n_state;

    t_atom  r_mem [MAX_ATOMS];
    t_atom  r_rd;

    logic [31:0]   r_probe;
    logic [8:0]    r_count;
    logic [AW-1:0] r_clr;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_limit;
    logic [31:0]   r_px, r_py, r_pz;
    logic [32:0]   r_dx, r_dy, r_dz;
    logic [65:0]   r_sq;
    logic [67:0]   r_acc;
    logic [5:0]    r_cnt;
    logic [36:0]   r_rem;
    logic [33:0]   r_root;
    logic          r_neg;
    logic [49:0]   r_q;
    logic [31:0]   r_drem;
    logic signed [22:0] r_y;
    logic signed [54:0] r_y2;
    logic [31:0]   r_g;
    logic signed [7:0] r_n;
    logic [32:0]   r_term;
    logic [31:0]   r_x;
    logic [32:0]   r_sum;
    logic [3:0]    r_k;
    logic          r_ph;
    logic [63:0]   r_prod;
    logic [63:0]   r_tval;
    logic          r_tsat;
    logic [47:0]   r_total;
    logic          r_sat;
    logic          r_out_vld;
    logic [47:0]   r_out_data;
    logic          r_out_sat;

    logic          w_pop;
    logic          w_load;
    logic [16:0]   w_idx_ext;
    logic [16:0]   w_cnt_ext;
    logic [16:0]   w_lim17;
    logic [CW-1:0] w_idx_inc;
    logic          w_last;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    t_atom         w_wdata;
    logic [32:0]   w_da, w_db, w_dc;
    logic [32:0]   w_sq_op;
    logic [36:0]   w_rem_sh;
    logic [36:0]   w_trial;
    logic          w_rbit;
    logic signed [35:0] w_arg;
    logic [35:0]   w_mag;
    logic [32:0]   w_drem_sh;
    logic          w_dge;
    logic [63:0]   w_gmul;
    logic [64:0]   w_tmul;
    logic [68:0]   w_rmul;
    logic signed [8:0] w_s;
    logic [8:0]    w_ns;
    logic [6:0]    w_sh;
    logic [63:0]   w_hi;
    logic [63:0]   w_shv;
    logic          w_sov;
    logic [63:0]   w_room;
    logic          w_out_free;

    assign w_pop     = (r_state == S_IDLE) && i_item_vld;
    assign w_load    = w_pop && !i_item.is_query;
    assign o_ctl.pop      = w_pop;
    assign o_ctl.clearing = (r_state == S_CLEAR);

    assign w_idx_ext = 17'(i_item.idx);
    assign w_cnt_ext = 17'(r_count);
    assign w_lim17   = (w_cnt_ext > MAX_EXT) ? MAX_EXT : w_cnt_ext;
    assign w_idx_inc = r_idx + 1'b1;
    assign w_last    = (w_idx_inc == r_limit);

    assign w_we    = (r_state == S_CLEAR) || w_load;
    assign w_waddr = (r_state == S_CLEAR) ? r_clr : w_idx_ext[AW-1:0];
    assign w_wdata = (r_state == S_CLEAR) ? '0 : i_item.atom;

    assign w_out_free = !r_out_vld || m_axis_tready;

    // Absolute differences of sign-extended coordinates.
    function automatic logic [32:0] f_absdiff(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] d;
        d = {a[31], a} - {b[31], b};
        return d[32] ? (33'd0 - d) : d;
    endfunction

    assign w_da = f_absdiff(r_rd.x, r_px);
    assign w_db = f_absdiff(r_rd.y, r_py);
    assign w_dc = f_absdiff(r_rd.z, r_pz);

    always_comb begin
        case (r_cnt[1:0])
            2'd0:    w_sq_op = r_dx;
            2'd1:    w_sq_op = r_dy;
            2'd2:    w_sq_op = r_dz;
            default: w_sq_op = '0;
        endcase
    end

    // One bit of the square root per cycle.
    assign w_rem_sh = {r_rem[34:0], r_acc[67:66]};
    assign w_trial  = {1'b0, r_root, 2'b01};
    assign w_rbit   = (w_rem_sh >= w_trial);

    assign w_arg = $signed({2'b00, r_root}) - $signed({4'b0000, r_probe});
    assign w_mag = w_arg[35] ? 36'(-w_arg) : 36'(w_arg);

    // One quotient bit per cycle.
    assign w_drem_sh = {r_drem, r_q[49]};
    assign w_dge     = (w_drem_sh >= {1'b0, r_rd.decay});

    assign w_gmul = r_y2[45:14] * LN2_Q32;
    // The leading series term is exactly one, so the full 33-bit term is multiplied.
    assign w_tmul = r_term * r_g;
    assign w_rmul = r_x * f_recip(r_k);

    // Final scaling by 2^(n-31).
    assign w_s     = 9'(r_n) - 9'sd31;
    assign w_ns    = 9'd0 - w_s;
    assign w_sh    = w_s[6:0];
    assign w_hi    = r_prod >> (7'd48 - w_sh);
    assign w_sov   = (r_prod != '0) && ((w_sh >= 7'd48) || (w_hi != '0));
    assign w_shv   = w_s[8] ? ((w_ns >= 9'd64) ? 64'd0 : (r_prod >> w_ns[5:0]))
                            : (r_prod << w_sh);
    assign w_room  = 64'(OUT_MAX - r_total);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr == LAST_ADDR) n_state = S_IDLE;
            S_IDLE: begin
                if (w_pop && i_item.is_query) begin
                    n_state = (w_lim17 == '0) ? S_DONE : S_READ;
                end
            end
            S_READ:  n_state = S_DIFF;
            S_DIFF: begin
                if (r_rd.rate != '0) n_state = S_SQ;
                else if (w_last)     n_state = S_DONE;
                else                 n_state = S_READ;
            end
            S_SQ:    if (r_cnt[1:0] == 2'd3) n_state = S_SQRT;
            S_SQRT:  if (r_cnt == 6'd0) n_state = S_ARG;
            S_ARG:   n_state = S_DIV;
            S_DIV:   if (r_cnt == 6'd0) n_state = S_CHK;
            S_CHK: begin
                if (!r_neg && (r_q > T_FAR))     n_state = S_ACC;
                else if (r_neg && (r_q > T_NEAR)) n_state = S_ACC;
                else                               n_state = S_LOG;
            end
            S_LOG:   n_state = S_LN;
            S_LN:    n_state = S_EXP;
            S_EXP:   if (r_ph && (r_k == EXP_LAST_K)) n_state = S_ESUM;
            S_ESUM:  n_state = S_PROD;
            S_PROD:  n_state = S_SHIFT;
            S_SHIFT: n_state = S_ACC;
            S_ACC:   n_state = w_last ? S_DONE : S_READ;
            S_DONE:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_probe   <= '0;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_PROBE_RADIUS: r_probe <= i_cfg_wdata;
                    CFG_ATOM_COUNT:   r_count <= i_cfg_wdata[8:0];
                    default:          r_probe <= r_probe;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) r_out_vld <= 1'b0;
            if ((r_state == S_DONE) && w_out_free) r_out_vld <= 1'b1;
        end
    end

    // Entry table.
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        if (r_state == S_READ) r_rd <= r_mem[r_idx[AW-1:0]];
    end

    // Term datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_idx   <= '0;
                r_limit <= w_lim17[CW-1:0];
                r_px    <= i_item.atom.x;
                r_py    <= i_item.atom.y;
                r_pz    <= i_item.atom.z;
                r_total <= '0;
                r_sat   <= 1'b0;
            end
            S_DIFF: begin
                r_dx  <= w_da;
                r_dy  <= w_db;
                r_dz  <= w_dc;
                r_sq  <= '0;
                r_acc <= '0;
                r_cnt <= '0;
                if (r_rd.rate == '0) r_idx <= w_idx_inc;
            end
            S_SQ: begin
                r_sq  <= w_sq_op * w_sq_op;
                r_acc <= r_acc + 68'(r_sq);
                r_cnt <= (r_cnt[1:0] == 2'd3) ? 6'd33 : r_cnt + 6'd1;
                r_rem  <= '0;
                r_root <= '0;
            end
            S_SQRT: begin
                r_acc  <= {r_acc[65:0], 2'b00};
                r_rem  <= w_rbit ? (w_rem_sh - w_trial) : w_rem_sh;
                r_root <= {r_root[32:0], w_rbit};
                r_cnt  <= (r_cnt == 6'd0) ? 6'd49 : r_cnt - 6'd1;
            end
            S_ARG: begin
                r_neg  <= w_arg[35];
                r_q    <= {w_mag[33:0], 16'd0};
                r_drem <= '0;
            end
            S_DIV: begin
                r_drem <= w_dge ? 32'(w_drem_sh - {1'b0, r_rd.decay}) : w_drem_sh[31:0];
                r_q    <= {r_q[48:0], w_dge};
                r_cnt  <= r_cnt - 6'd1;
            end
            S_CHK: begin
                r_y    <= r_neg ? $signed(r_q[22:0]) : -$signed(r_q[22:0]);
                r_tval <= r_neg ? 64'(OUT_MAX) : '0;
                r_tsat <= r_neg;
            end
            S_LOG: begin
                r_y2 <= r_y * $signed(LOG2E_Q30);
            end
            S_LN: begin
                r_g    <= w_gmul[63:32];
                r_n    <= r_y2[53:46];
                r_term <= EXP_ONE;
                r_sum  <= '0;
                r_k    <= 4'd1;
                r_ph   <= 1'b0;
            end
            S_EXP: begin
                if (!r_ph) begin
                    r_x   <= w_tmul[63:32];
                    r_sum <= r_sum + r_term;
                    r_ph  <= 1'b1;
                end else begin
                    r_term <= 33'(w_rmul[67:36]);
                    r_k    <= r_k + 4'd1;
                    r_ph   <= 1'b0;
                end
            end
            S_ESUM: r_sum <= r_sum + r_term;
            S_PROD: r_prod <= r_rd.rate * r_sum[32:1];
            S_SHIFT: begin
                r_tsat <= !w_s[8] && w_sov;
                r_tval <= (!w_s[8] && w_sov) ? 64'(OUT_MAX) : w_shv;
            end
            S_ACC: begin
                if (r_tval > w_room) begin
                    r_total <= OUT_MAX;
                    r_sat   <= 1'b1;
                end else begin
                    r_total <= r_total + r_tval[47:0];
                end
                if (r_tsat) r_sat <= 1'b1;
                r_idx <= w_idx_inc;
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_out_data <= r_total;
                    r_out_sat  <= r_sat;
                end
            end
            default: r_cnt <= r_cnt;
        endcase
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_sat;

    a_no_pop_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_ctl.pop)
        else $error("queue popped during clearing pass");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_idx < r_limit))
        else $error("scan index beyond limit");

    a_sat_term_clamps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_ACC) && r_tsat) |=> ((r_total == OUT_MAX) && r_sat))
        else $error("saturated term did not clamp the sum");

    a_decay_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rd.decay != '0))
        else $error("division by zero decay length");

    a_result_posted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && w_out_free) |=> (r_out_vld && (r_state == S_IDLE)))
        else $error("finished sum not posted");

endmodule

/* sv/distance_quench_rate_sum_top.sv */
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready   tdata: atom_index, x_pos, y_pos, z_pos,
//                                                     rate_const, decay_length; tuser: op
// m_axis    out        m_axis_tvalid / m_axis_tready   tdata: summed rate; tuser: saturated
// cfg       in         i_cfg_wr_en                     i_cfg_index, i_cfg_wdata
//
// A load word is written into the table as it leaves the head of the queue. A query scans
// the table entry by entry: an entry with zero rate is only read, every other entry passes
// the bit-serial square root and the bit-serial divider, and a term cut off as far or near
// then skips the logarithm and the exponential series.
// After reset a clearing pass zeroes the table; no word is taken then.
// A two-word queue parts the front from the engine, and a result register lets the next
// query start while the previous sum waits on m_axis_tready.
module distance_quench_rate_sum_top import dqrs_pkg::*; #(
    parameter int MAX_ATOMS = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // atom_index [7:0], x_pos [39:8], y_pos [71:40], z_pos [103:72],
    // rate_const [135:104], decay_length [167:136]
    input  logic [167:0] s_axis_tdata,
    // op [0]: zero loads an entry, one queries a dye position
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // summed rate [47:0]
    output logic [47:0]  m_axis_tdata,
    // saturated [0]
    output logic         m_axis_tuser,
    input  logic         i_cfg_wr_en,
    input  logic         i_cfg_index,
    input  logic [31:0]  i_cfg_wdata
);

    // Words that were accepted and classified, waiting for the engine.
    t_item     w_item;
    logic      w_item_vld;
    t_back_ctl w_ctl;

    // The front takes words off the slave side, substitutes the default decay length and
    // drops loads that address past the table.
    dqrs_front #(
        .MAX_ATOMS (MAX_ATOMS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_item        (w_item),
        .o_item_vld    (w_item_vld),
        .i_ctl         (w_ctl)
    );

    // The back holds the table and the configuration, and runs the per-entry sequence.
    dqrs_back #(
        .MAX_ATOMS (MAX_ATOMS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (w_item),
        .i_item_vld    (w_item_vld),
        .o_ctl         (w_ctl),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

/* tb/distance_quench_rate_sum_top_tb.sv */
`timescale 1ns / 100ps

module distance_quench_rate_sum_top_tb import dqrs_pkg::*;;

    localparam int     TABLE_DEPTH = 256;
    localparam longint CYCLE_LIMIT = 20000000;
    // log2(e) in Q2.30 and ln(2) in Q0.32, as the term datapath uses them.
    localparam longint LOG2E_FIX   = 1549082005;
    localparam longint LN2_FIX     = 64'd2977044472;
    localparam int     FAR_T       = 50 * 65536;
    localparam int     NEAR_T      = 40 * 65536;
    localparam int     END_DRAIN   = 300;

    typedef enum logic [1:0] {
        ROW_LOAD,
        ROW_QUERY,
        ROW_SET_PROBE,
        ROW_SET_COUNT
    } t_row_kind;

    typedef struct {
        logic        op;
        logic [7:0]  idx;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] rate;
        logic [31:0] decay;
    } t_word;

    typedef struct {
        logic [47:0] total;
        logic        sat;
    } t_rate_sum;

    // One line of the directed table. A configuration row carries its value in x.
    typedef struct {
        t_row_kind   kind;
        t_word       w;
        logic        typed;
        t_rate_sum   known;
    } t_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [167:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [47:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         i_cfg_wr_en;
    logic         i_cfg_index;
    logic [31:0]  i_cfg_wdata;

    // The testbench's own copy of the quencher table and the registers.
    logic [31:0] quench_x     [TABLE_DEPTH];
    logic [31:0] quench_y     [TABLE_DEPTH];
    logic [31:0] quench_z     [TABLE_DEPTH];
    logic [31:0] quench_rate  [TABLE_DEPTH];
    logic [31:0] quench_decay [TABLE_DEPTH];
    logic [31:0] probe_radius_q;
    logic [8:0]  atom_count_q;

    // Sums still owed by the block, oldest first.
    t_rate_sum pending_sums[$];

    int     error_count;
    longint cycle_count = 0;
    bit     calm;          // when set, neither side inserts gaps
    int     ready_hold;

    distance_quench_rate_sum_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // One quenching term in Q.16, following the fixed-point datapath step by step.
    function automatic logic [63:0] quench_term(input int idx, input longint px,
                                                input longint py, input longint pz,
                                                inout logic sat);
        longint      ax, ay, az, arg, y, y2;
        logic [63:0] dx, dy, dz, mag, tmag, zq, f, g, term, expg, prod;
        logic [67:0] sq;
        logic [69:0] rem, root, trial;
        int          n, s;
        ax = longint'(signed'(quench_x[idx]));
        ay = longint'(signed'(quench_y[idx]));
        az = longint'(signed'(quench_z[idx]));
        dx = (ax >= px) ? ax - px : px - ax;
        dy = (ay >= py) ? ay - py : py - ay;
        dz = (az >= pz) ? az - pz : pz - az;
        sq = 68'(dx * dx) + 68'(dy * dy) + 68'(dz * dz);
        rem  = '0;
        root = '0;
        for (int i = 33; i >= 0; i--) begin
            rem   = (rem << 2) | 70'(sq[2*i +: 2]);
            trial = (root << 2) | 70'd1;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = (root << 1) | 70'd1;
            end else begin
                root = root << 1;
            end
        end
        arg  = longint'(root) - longint'({32'b0, probe_radius_q});
        mag  = (arg < 0) ? -arg : arg;
        tmag = (mag << 16) / {32'b0, quench_decay[idx]};
        if (arg >= 0) begin
            if (tmag > FAR_T) begin
                return 64'd0;
            end
            y = -longint'(tmag);
        end else begin
            if (tmag > NEAR_T) begin
                sat = 1'b1;
                return {16'b0, OUT_MAX};
            end
            y = longint'(tmag);
        end
        // exp(y) = 2^n * exp(g), y = -t or +t: split the base-2 exponent into integer and fraction.
        y2 = y * LOG2E_FIX;
        zq = y2 + (longint'(128) <<< 46);
        n  = int'(zq >> 46) - 128;
        f  = (zq >> 14) & 64'hFFFF_FFFF;
        g  = (f * LN2_FIX) >> 32;
        expg = 64'h1_0000_0000;
        term = 64'h1_0000_0000;
        for (int k = 1; k <= 13; k++) begin
            term = ((term * g) >> 32) / k;
            expg = expg + term;
        end
        prod = {32'b0, quench_rate[idx]} * (expg >> 1);
        s = n - 31;
        if (s >= 0) begin
            if (prod != 0 && (s >= 48 || (prod >> (48 - s)) != 0)) begin
                sat = 1'b1;
                return {16'b0, OUT_MAX};
            end
            return prod << s;
        end
        if (-s >= 64) begin
            return 64'd0;
        end
        return prod >> (-s);
    endfunction

    function automatic t_rate_sum predict_rate_sum(input t_word w);
        t_rate_sum   res;
        logic [63:0] total, t, cap;
        logic        sat;
        int          limit;
        total = '0;
        sat   = 1'b0;
        cap   = {16'b0, OUT_MAX};
        limit = (int'(atom_count_q) > TABLE_DEPTH) ? TABLE_DEPTH : int'(atom_count_q);
        for (int i = 0; i < limit; i++) begin
            if (quench_rate[i] != 0) begin
                t = quench_term(i, longint'(signed'(w.x)), longint'(signed'(w.y)),
                                longint'(signed'(w.z)), sat);
                if (t > cap - total) begin
                    total = cap;
                    sat   = 1'b1;
                end else begin
                    total = total + t;
                end
            end
        end
        res.total = total[47:0];
        res.sat   = sat;
        return res;
    endfunction

    // Bring the table copy up to date, or queue the sum a query is owed.
    task automatic take_word(input t_word w);
        if (w.op == 1'b0) begin
            quench_x[w.idx]     = w.x;
            quench_y[w.idx]     = w.y;
            quench_z[w.idx]     = w.z;
            quench_rate[w.idx]  = w.rate;
            // A zero decay length stands for one angstrom.
            quench_decay[w.idx] = (w.decay == 0) ? ONE_ANGSTROM : w.decay;
        end else begin
            pending_sums = {pending_sums, predict_rate_sum(w)};
        end
    endtask

    // Present one word, with a random gap ahead of it, and hold it until it is taken.
    // With no gap, tvalid simply stays high from the previous word.
    task automatic send_word(input t_word w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {w.decay, w.rate, w.z, w.y, w.x, w.idx};
        s_axis_tuser  <= w.op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        take_word(w);
    endtask

    // Stop sending, then wait for every owed sum plus time for a trailing load.
    task automatic drain_to_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_sums.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic index, input logic [31:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (index == CFG_PROBE_RADIUS) begin
            probe_radius_q = value;
        end else begin
            atom_count_q = value[8:0];
        end
        @(posedge i_clk);
    endtask

    // Result side: check each taken word, then decide the next tready.
    always @(posedge i_clk) begin
        t_rate_sum want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_sums.size() == 0) begin
                    report_mismatch($sformatf("unexpected word total %0d", m_axis_tdata));
                end else begin
                    want = pending_sums.pop_front();
                    if (m_axis_tdata !== want.total) begin
                        report_mismatch($sformatf("rate sum %0d, expected %0d",
                                                  m_axis_tdata, want.total));
                    end
                    if (m_axis_tuser !== want.sat) begin
                        report_mismatch($sformatf("saturated %0b, expected %0b",
                                                  m_axis_tuser, want.sat));
                    end
                end
            end
            if (ready_hold > 0) begin
                ready_hold    <= ready_hold - 1;
                m_axis_tready <= 1'b0;
            end else if (calm || $urandom_range(0, 3) != 0) begin
                m_axis_tready <= 1'b1;
            end else begin
                ready_hold    <= pick_gap();
                m_axis_tready <= 1'b0;
            end
        end
    end

    // Random coordinate: mostly within a few tens of angstroms, sometimes anywhere.
    function automatic logic [31:0] rand_coord();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom();
        end
        return 32'($signed($urandom_range(0, 2 << 21)) - (1 << 21));
    endfunction

    function automatic t_word rand_word(input int count);
        t_word w;
        int    r;
        w.op    = ($urandom_range(0, 99) < 40);
        w.x     = rand_coord();
        w.y     = rand_coord();
        w.z     = rand_coord();
        r       = $urandom_range(0, 9);
        w.rate  = (r == 0) ? 32'd0 : (r == 1) ? $urandom() : $urandom_range(1, 1 << 24);
        r       = $urandom_range(0, 9);
        w.decay = (r == 0) ? 32'd0 : (r == 1) ? $urandom()
                                   : $urandom_range(1 << 14, 1 << 19);
        // Most loads fill the scanned range; stray ones elsewhere stay mostly
        // inactive so that long scans remain affordable.
        if (count > 0 && count <= 16 && $urandom_range(0, 99) < 85) begin
            w.idx = 8'($urandom_range(0, count - 1));
        end else begin
            w.idx = 8'($urandom_range(0, 255));
            if (w.idx >= 16) begin
                w.rate = 32'd0;
            end
        end
        return w;
    endfunction

    function automatic t_row mk(input t_row_kind kind, input logic [7:0] idx,
                                input logic [31:0] x, input logic [31:0] y,
                                input logic [31:0] z, input logic [31:0] rate,
                                input logic [31:0] decay);
        t_row r;
        r.kind  = kind;
        r.w.op  = (kind == ROW_QUERY);
        r.w.idx = idx;
        r.w.x   = x;
        r.w.y   = y;
        r.w.z   = z;
        r.w.rate  = rate;
        r.w.decay = decay;
        r.typed = 1'b0;
        r.known = '{48'd0, 1'b0};
        return r;
    endfunction

    function automatic t_row known(input t_row r, input logic [47:0] total, input logic sat);
        t_row k;
        k       = r;
        k.typed = 1'b1;
        k.known = '{total, sat};
        return k;
    endfunction

    t_row directed[$];

    task automatic add_row(input t_row r);
        directed = {directed, r};
    endtask

    initial begin
        int   counts[9];
        int   lengths[9];
        t_word w;
        logic [31:0] probe;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = CFG_PROBE_RADIUS;
        i_cfg_wdata   = '0;
        error_count   = 0;
        calm          = 1'b0;
        ready_hold    = 0;
        probe_radius_q = '0;
        atom_count_q   = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            quench_x[i]     = '0;
            quench_y[i]     = '0;
            quench_z[i]     = '0;
            quench_rate[i]  = '0;
            quench_decay[i] = '0;
        end

        // Directed table. Coordinates are Q16.16 angstroms.
        // A query straight after reset scans nothing.
        add_row(known(mk(ROW_QUERY, 0, 0, 0, 0, 0, 0), 48'd0, 1'b0));
        add_row(mk(ROW_SET_COUNT, 0, 4, 0, 0, 0, 0));
        // The table is cleared, so every entry is inactive.
        add_row(known(mk(ROW_QUERY, 0, 32'hFFFF_FFFF, 0, 32'h8000_0000, 0, 0),
                      48'd0, 1'b0));
        // Unit rate at the dye position, zero decay taken as one angstrom: exp(0) = 1.
        add_row(mk(ROW_LOAD, 0, 0, 0, 0, 32'h1_0000, 0));
        add_row(known(mk(ROW_QUERY, 0, 0, 0, 0, 0, 0), 48'd65536, 1'b0));
        add_row(mk(ROW_LOAD, 1, 0, 0, 0, 32'h1_0000, 32'h1_0000));
        // A probe of 100 angstroms makes both quenchers overlap the dye.
        add_row(mk(ROW_SET_PROBE, 0, 100 << 16, 0, 0, 0, 0));
        add_row(known(mk(ROW_QUERY, 0, 0, 0, 0, 0, 0), OUT_MAX, 1'b1));
        add_row(mk(ROW_SET_PROBE, 0, 0, 0, 0, 0, 0));
        // A quencher 100 angstroms away is past the far cutoff and adds nothing.
        add_row(mk(ROW_LOAD, 1, 100 << 16, 0, 0, 32'h1_0000, 32'h1_0000));
        add_row(known(mk(ROW_QUERY, 0, 0, 0, 0, 0, 0), 48'd65536, 1'b0));
        // Largest rate, and opposite corners of the coordinate range.
        add_row(mk(ROW_LOAD, 2, 0, 0, 0, 32'hFFFF_FFFF, 0));
        add_row(mk(ROW_LOAD, 3, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF));
        add_row(mk(ROW_QUERY, 0, 0, 0, 0, 0, 0));
        add_row(mk(ROW_QUERY, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   0, 0));
        // Four strong quenchers ten angstroms inside the probe overflow the sum.
        add_row(mk(ROW_LOAD, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'h1_0000));
        add_row(mk(ROW_LOAD, 1, 0, 0, 0, 32'hFFFF_FFFF, 32'h1_0000));
        add_row(mk(ROW_LOAD, 3, 0, 0, 0, 32'hFFFF_FFFF, 32'h1_0000));
        add_row(mk(ROW_SET_PROBE, 0, 10 << 16, 0, 0, 0, 0));
        add_row(mk(ROW_QUERY, 0, 0, 0, 0, 0, 0));
        // Last table entry, then a scan of the whole table.
        add_row(mk(ROW_LOAD, 255, 32'h0003_8000, 32'hFFFE_0000, 0,
                   32'h0002_0000, 32'h0000_8000));
        add_row(mk(ROW_SET_COUNT, 0, 256, 0, 0, 0, 0));
        add_row(mk(ROW_QUERY, 0, 32'h0001_0000, 0, 32'hFFFF_0000, 0, 0));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The opening rows run without gaps; the rest of the run idles at random.
        calm = 1'b1;
        foreach (directed[i]) begin
            if (i == 8) begin
                calm = 1'b0;
            end
            case (directed[i].kind)
                ROW_SET_PROBE: begin
                    drain_to_idle();
                    write_reg(CFG_PROBE_RADIUS, directed[i].w.x);
                end
                ROW_SET_COUNT: begin
                    drain_to_idle();
                    write_reg(CFG_ATOM_COUNT, directed[i].w.x);
                end
                default: begin
                    send_word(directed[i].w);
                    if (directed[i].typed) begin
                        pending_sums[pending_sums.size() - 1] = directed[i].known;
                    end
                end
            endcase
        end

        // Random phases, each with its own probe radius and scan length. Small
        // counts keep queries cheap; one short phase scans the full table.
        counts  = '{1, 3, 6, 5, 2, 6, 0, 4, 256};
        lengths = '{190, 190, 190, 190, 190, 190, 190, 190, 30};
        for (int p = 0; p < 9; p++) begin
            drain_to_idle();
            case (p % 4)
                0: probe = $urandom_range(0, 12 << 16);
                1: probe = (p == 5) ? 32'hFFFF_FFFF : 32'd0;
                2: probe = $urandom();
                default: probe = $urandom_range(0, 4 << 16);
            endcase
            write_reg(CFG_PROBE_RADIUS, probe);
            write_reg(CFG_ATOM_COUNT, counts[p]);
            calm = (p == 3);
            for (int k = 0; k < lengths[p]; k++) begin
                w = rand_word(counts[p]);
                if (counts[p] > 16 && $urandom_range(0, 2) != 0) begin
                    w.op = 1'b0;
                end
                send_word(w);
            end
        end

        calm = 1'b0;
        drain_to_idle();
        repeat (END_DRAIN) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* distance_quench_rate_sum_top.f */
sv/dqrs_pkg.sv
sv/dqrs_front.sv
sv/dqrs_back.sv
sv/distance_quench_rate_sum_top.sv
tb/distance_quench_rate_sum_top_tb.sv
